/* rtl/arc_pkg.sv */
`default_nettype none
package arc_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned IDX_W    = 16;
  localparam int unsigned CNT_W    = 17;
  localparam int unsigned OFFS_W   = 18;
  localparam int unsigned MAX_WORDS_DEF = 65536;

  // Instruction class fields.
  localparam logic [1:0] OP_DATA_PROC  = 2'b00;
  localparam logic [1:0] OP_LOAD_STORE = 2'b01;
  localparam logic [2:0] OP_LOAD_MULTI = 3'b100;
  localparam logic [3:0] OP_BRANCH_LNK = 4'hB;
  localparam logic [3:0] RN_PC         = 4'hF;

  // PC reads two instructions ahead.
  localparam logic [WORD_W-1:0] PC_AHEAD = 32'd8;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [IDX_W-1:0]  idx;
    logic [CNT_W-1:0]  cnt;
  } arc_stage_t;

  typedef struct packed {
    logic [OFFS_W-1:0]        word_offset;
    logic                     pc_relative;
    logic                     is_call;
    logic                     has_target;
    logic signed [WORD_W-1:0] ref_target;
    logic [CNT_W-1:0]         data_words_seen;
  } arc_result_t;

endpackage
`default_nettype wire

/* rtl/arc_ifs.sv */
`default_nettype none
interface arc_in_if;
  logic                        valid;
  logic                        ready;
  logic [arc_pkg::WORD_W-1:0]  instruction_word;
  logic                        is_data_word;
  logic                        first_of_listing;

  modport source (output valid, output instruction_word, output is_data_word,
                  output first_of_listing, input ready);
  modport sink   (input valid, input instruction_word, input is_data_word,
                  input first_of_listing, output ready);
endinterface

interface arc_out_if;
  logic                              valid;
  logic                              ready;
  logic [arc_pkg::OFFS_W-1:0]        word_offset;
  logic                              pc_relative;
  logic                              is_call;
  logic                              has_target;
  logic signed [arc_pkg::WORD_W-1:0] ref_target;
  logic [arc_pkg::CNT_W-1:0]         data_words_seen;

  modport source (output valid, output word_offset, output pc_relative, output is_call,
                  output has_target, output ref_target, output data_words_seen,
                  input ready);
  modport sink   (input valid, input word_offset, input pc_relative, input is_call,
                  input has_target, input ref_target, input data_words_seen,
                  output ready);
endinterface

interface arc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [arc_pkg::WORD_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/arc_front.sv */
`default_nettype none
module arc_front #(
  parameter int unsigned MAX_WORDS = arc_pkg::MAX_WORDS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  arc_in_if.sink              in_bus,
  input  logic                advance,
  output logic                s1_valid,
  output arc_pkg::arc_stage_t s1
);
  import arc_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt, idx_base, idx_inc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_base;
  logic             s1_valid_r;
  arc_stage_t       s1_r;
  logic             accept;

  assign in_bus.ready = !s1_valid_r || advance;
  assign accept       = in_bus.valid && in_bus.ready;

  always_comb begin
    idx_base = in_bus.first_of_listing ? '0 : idx_r;
    cnt_base = in_bus.first_of_listing ? '0 : cnt_r;
    cnt_nxt  = cnt_base;
    // The data count sticks at its top value.
    if (in_bus.is_data_word && cnt_base != '1) begin
      cnt_nxt = cnt_base + CNT_W'(1);
    end
    idx_inc = idx_base + IDX_W'(1);
    idx_nxt = (32'(idx_inc) >= MAX_WORDS) ? '0 : idx_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      cnt_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        idx_r <= idx_nxt;
        cnt_r <= cnt_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.word <= in_bus.instruction_word;
      s1_r.idx  <= idx_base;
      s1_r.cnt  <= cnt_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule
`default_nettype wire

/* rtl/arc_decode.sv */
`default_nettype none
module arc_decode (
  input  arc_pkg::arc_stage_t         stage,
  input  logic [arc_pkg::WORD_W-1:0]  function_start,
  output arc_pkg::arc_result_t        result
);
  import arc_pkg::*;

  logic [WORD_W-1:0]     w;
  logic [WORD_W-1:0]     pc;
  logic [WORD_W-1:0]     imm12;
  logic [WORD_W-1:0]     imm8;
  logic [2*WORD_W-1:0]   rot_pair;
  logic [WORD_W-1:0]     rot_imm;
  logic [WORD_W-1:0]     br_disp;
  logic [WORD_W-1:0]     target;
  logic [WORD_W+1:0]     call_sum;
  logic                  rn_is_pc;
  logic                  pcrel;
  logic                  has;
  logic                  call;

  always_comb begin
    w        = stage.word;
    pc       = {{(WORD_W-IDX_W-2){1'b0}}, stage.idx, 2'b00} + PC_AHEAD;
    rn_is_pc = (w[19:16] == RN_PC);
    imm12    = {20'd0, w[11:0]};
    imm8     = {24'd0, w[7:0]};
    // Rotating the doubled word right gives a rotate of imm8 by twice the field.
    rot_pair = {imm8, imm8} >> {w[11:8], 1'b0};
    rot_imm  = rot_pair[WORD_W-1:0];
    br_disp  = {{6{w[23]}}, w[23:0], 2'b00};

    pcrel  = 1'b0;
    has    = 1'b0;
    call   = 1'b0;
    target = '0;

    unique case (w[27:26])
      OP_LOAD_STORE: begin
        if (rn_is_pc) begin
          pcrel = 1'b1;
          if (!w[25]) begin
            has    = 1'b1;
            target = w[23] ? (pc + imm12) : (pc - imm12);
          end
        end
      end
      OP_DATA_PROC: begin
        if (rn_is_pc) begin
          pcrel = 1'b1;
          if (w[25]) begin
            has    = 1'b1;
            target = pc + rot_imm;
          end
        end
      end
      default: begin
        if (w[27:25] != OP_LOAD_MULTI && w[27:24] == OP_BRANCH_LNK) begin
          has    = 1'b1;
          target = pc + br_disp;
        end
      end
    endcase

    // Signed target plus unsigned start, compared against zero without wrap.
    call_sum = {{2{target[WORD_W-1]}}, target} + {2'b00, function_start};
    if (has && !pcrel) begin
      call = !call_sum[WORD_W+1] && (call_sum != '0);
    end

    result.word_offset     = {stage.idx, 2'b00};
    result.pc_relative     = pcrel;
    result.is_call         = call;
    result.has_target      = has;
    result.ref_target      = target;
    result.data_words_seen = stage.cnt;
  end

endmodule
`default_nettype wire

/* rtl/arm_pc_relative_ref_classifier.sv */
`default_nettype none
// Classifies a stream of 32-bit ARM instruction words, one beat per clock unless stalled by
// the result side. Each input beat yields exactly one result beat: the word's byte offset,
// whether it is a load/store or data-processing op based on the PC, the target it references
// (PC taken as offset + 8, wrapping to 32 bits), a call flag for branch-with-link, and the
// running count of data words. It is a two-register pipeline (input stage holding the word
// and counters, result register after the decode); both stages advance together whenever
// the result side takes a beat or is empty. The user must write function_start through the
// cfg channel only while the block is idle; the block does not enforce this. That value only
// affects the call flag. A first_of_listing beat restarts the word index and data count.
module arm_pc_relative_ref_classifier #(
  parameter int unsigned MAX_WORDS = arc_pkg::MAX_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  arc_in_if.sink     in_bus,
  arc_out_if.source  out_bus,
  arc_cfg_if.sink    cfg_bus
);
  import arc_pkg::*;

  logic              s1_valid;
  arc_stage_t        s1;
  arc_result_t       dec;
  arc_result_t       out_r;
  logic              out_valid_r;
  logic              advance;
  logic [WORD_W-1:0] function_start_r;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      function_start_r <= '0;
    end else if (cfg_bus.valid) begin
      function_start_r <= cfg_bus.data;
    end
  end

  // The result register frees up when empty or when its beat is taken.
  assign advance = s1_valid && (!out_valid_r || out_bus.ready);

  arc_front #(
    .MAX_WORDS (MAX_WORDS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  arc_decode u_decode (
    .stage          (s1),
    .function_start (function_start_r),
    .result         (dec)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= dec;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.word_offset     = out_r.word_offset;
  assign out_bus.pc_relative     = out_r.pc_relative;
  assign out_bus.is_call         = out_r.is_call;
  assign out_bus.has_target      = out_r.has_target;
  assign out_bus.ref_target      = out_r.ref_target;
  assign out_bus.data_words_seen = out_r.data_words_seen;

endmodule
`default_nettype wire

/* rtl/arc_checker.sv */
`default_nettype none
module arc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [arc_pkg::OFFS_W-1:0]        word_offset,
  input logic                              pc_relative,
  input logic                              is_call,
  input logic                              has_target,
  input logic signed [arc_pkg::WORD_W-1:0] ref_target
);

  // A stalled result beat must not disappear.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Only a branch-with-link raises the call flag, and it always carries a target.
  a_call_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_call |-> has_target && !pc_relative)
    else $error("call flag without a branch target");

  a_no_target_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_target |-> ref_target == '0)
    else $error("target nonzero while none computed");

  a_offset_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> word_offset[1:0] == 2'b00)
    else $error("word offset not word aligned");

endmodule

bind arm_pc_relative_ref_classifier arc_checker u_arc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .word_offset (out_bus.word_offset),
  .pc_relative (out_bus.pc_relative),
  .is_call     (out_bus.is_call),
  .has_target  (out_bus.has_target),
  .ref_target  (out_bus.ref_target)
);
`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import arc_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              dat;
    logic              first;
    logic              typed;
    arc_result_t       res;
  } dir_row_t;

  localparam arc_result_t NO_RES = '0;
  localparam int N_DIR = 24;
  localparam int N_RAND_PHASE = 6;
  localparam int RAND_PER_PHASE = 160;
  localparam int SWEEP_WORDS = 120;

  // Rows with a typed result are read straight off the decode rules; the
  // rest go through decode_word.
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{32'hE59F0000, 1'b0, 1'b1, 1'b1, '{18'd0, 1'b1, 1'b0, 1'b1, 32'sh00000008, 17'd0}},
    '{32'hE51FFFFF, 1'b0, 1'b0, 1'b1, '{18'd4, 1'b1, 1'b0, 1'b1, 32'shFFFFF00D, 17'd0}},
    '{32'hE59FFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE28F0000, 1'b0, 1'b0, 1'b1, '{18'd12, 1'b1, 1'b0, 1'b1, 32'sh00000014, 17'd0}},
    '{32'hE28F00FF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE28F01FF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE28F0FFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE08F0001, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE79F0001, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE5910000, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hE89F0003, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hEB000000, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hEB7FFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hEB800000, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hFB000000, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hF59F0004, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hEA000000, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hEE000000, 1'b0, 1'b0, 1'b0, NO_RES},
    '{32'hFFFFFFFF, 1'b1, 1'b0, 1'b1, '{18'd72, 1'b0, 1'b0, 1'b0, 32'sh00000000, 17'd1}},
    '{32'h00000000, 1'b1, 1'b0, 1'b1, '{18'd76, 1'b0, 1'b0, 1'b0, 32'sh00000000, 17'd2}},
    '{32'h000F0000, 1'b1, 1'b0, 1'b0, NO_RES},
    '{32'hEBFFFFFE, 1'b0, 1'b1, 1'b1, '{18'd0, 1'b0, 1'b0, 1'b1, 32'sh00000000, 17'd0}},
    '{32'hE59F0000, 1'b1, 1'b1, 1'b1, '{18'd0, 1'b1, 1'b0, 1'b1, 32'sh00000008, 17'd1}},
    '{32'hEBFFFFFD, 1'b0, 1'b0, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst_n;

  arc_in_if  in_bus ();
  arc_out_if out_bus ();
  arc_cfg_if cfg_bus ();

  arm_pc_relative_ref_classifier dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus),
    .cfg_bus(cfg_bus)
  );

  always #1 clk = ~clk;

  // Shadow state of the classifier.
  logic [IDX_W-1:0]  word_idx;
  logic [CNT_W-1:0]  data_cnt;
  logic [WORD_W-1:0] fn_start;

  arc_result_t pending_results [$];
  int  n_err = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_gaps_on = 1'b1;

  function automatic arc_result_t decode_word(input logic [WORD_W-1:0] w, input logic dat,
                                              input logic first);
    arc_result_t r;
    logic [WORD_W-1:0] pc;
    logic [WORD_W-1:0] imm;
    logic [2*WORD_W-1:0] dbl;
    logic [WORD_W-1:0] tgt;
    longint sum;
    r = '0;
    if (first) begin
      word_idx = '0;
      data_cnt = '0;
    end
    pc = {14'b0, word_idx, 2'b00} + PC_AHEAD;
    if (dat && data_cnt != '1) begin
      data_cnt = data_cnt + CNT_W'(1);
    end
    r.word_offset = {word_idx, 2'b00};
    r.data_words_seen = data_cnt;
    if (w[27:26] == OP_LOAD_STORE) begin
      if (w[19:16] == RN_PC) begin
        r.pc_relative = 1'b1;
        if (!w[25]) begin
          r.has_target = 1'b1;
          r.ref_target = w[23] ? pc + {20'b0, w[11:0]} : pc - {20'b0, w[11:0]};
        end
      end
    end else if (w[27:26] == OP_DATA_PROC) begin
      if (w[19:16] == RN_PC) begin
        r.pc_relative = 1'b1;
        if (w[25]) begin
          imm = {24'b0, w[7:0]};
          dbl = {imm, imm} >> {w[11:8], 1'b0};
          r.has_target = 1'b1;
          r.ref_target = pc + dbl[WORD_W-1:0];
        end
      end
    end else if (w[27:25] == OP_LOAD_MULTI) begin
      r.pc_relative = 1'b0;
    end else if (w[27:24] == OP_BRANCH_LNK) begin
      tgt = pc + {{6{w[23]}}, w[23:0], 2'b00};
      r.has_target = 1'b1;
      r.ref_target = tgt;
      // The call test is a true signed sum, no wrap.
      sum = longint'($signed(tgt)) + longint'(fn_start);
      r.is_call = (sum > 0);
    end
    word_idx = word_idx + IDX_W'(1);
    return r;
  endfunction

  // Mostly instruction classes that reach the interesting decode paths,
  // with random content and condition codes; the rest is raw noise.
  function automatic logic [WORD_W-1:0] rand_word();
    logic [WORD_W-1:0] w;
    int pick;
    w = $urandom;
    pick = $urandom_range(99);
    if (pick < 22) begin
      w[27:26] = OP_LOAD_STORE;
      w[19:16] = RN_PC;
    end else if (pick < 44) begin
      w[27:26] = OP_DATA_PROC;
      w[19:16] = RN_PC;
    end else if (pick < 64) begin
      w[27:24] = OP_BRANCH_LNK;
    end else if (pick < 72) begin
      w[27:25] = OP_LOAD_MULTI;
    end
    return w;
  endfunction

  function automatic void cmp_field(input string name, input logic [WORD_W-1:0] want,
                                    input logic [WORD_W-1:0] got);
    if (want !== got) begin
      n_err++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  task automatic push_word(input logic [WORD_W-1:0] w, input logic dat, input logic first,
                           input logic typed, input arc_result_t given);
    arc_result_t pred;
    while (in_gaps_on && $urandom_range(99) < 21) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.instruction_word <= w;
    in_bus.is_data_word <= dat;
    in_bus.first_of_listing <= first;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    pred = decode_word(w, dat, first);
    pending_results.push_back(typed ? given : pred);
  endtask

  // Holds the sender off until every beat in flight has come out.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_start(input logic [WORD_W-1:0] v);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data <= v;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
    fn_start = v;
  endtask

  // Result side: random back-pressure and the comparison.
  initial begin
    arc_result_t want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        if (pending_results.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result beat, expected none, actual offset %h target %h",
                   $time, out_bus.word_offset, out_bus.ref_target);
        end else begin
          want = pending_results.pop_front();
          cmp_field("word_offset", WORD_W'(want.word_offset), WORD_W'(out_bus.word_offset));
          cmp_field("pc_relative", WORD_W'(want.pc_relative), WORD_W'(out_bus.pc_relative));
          cmp_field("is_call", WORD_W'(want.is_call), WORD_W'(out_bus.is_call));
          cmp_field("has_target", WORD_W'(want.has_target), WORD_W'(out_bus.has_target));
          cmp_field("ref_target", want.ref_target, out_bus.ref_target);
          cmp_field("data_words_seen", WORD_W'(want.data_words_seen),
                    WORD_W'(out_bus.data_words_seen));
        end
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= out_gaps_on ? ($urandom_range(99) >= 21) : 1'b1;
      end
    end
  end

  initial begin
    logic [WORD_W-1:0] start_val;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.instruction_word <= '0;
    in_bus.is_data_word <= 1'b0;
    in_bus.first_of_listing <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.data <= '0;
    word_idx = '0;
    data_cnt = '0;
    fn_start = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      push_word(DIR_ROWS[i].word, DIR_ROWS[i].dat, DIR_ROWS[i].first, DIR_ROWS[i].typed,
                DIR_ROWS[i].res);
    end
    wait_idle();

    for (int p = 0; p < N_RAND_PHASE; p++) begin
      case (p)
        0: start_val = 32'h0000_0020;
        1: start_val = 32'hFFFF_FFFF;
        2: start_val = 32'h0000_0000;
        3: start_val = 32'h8000_0000;
        4: start_val = 32'h7FFF_FFFF;
        default: start_val = $urandom_range(4096);
      endcase
      write_start(start_val);
      for (int i = 0; i < RAND_PER_PHASE; i++) begin
        push_word(rand_word(), $urandom_range(99) < 30, $urandom_range(99) < 2, 1'b0, NO_RES);
      end
      wait_idle();
    end

    // One long listing of data words with no gaps on either side.
    write_start($urandom);
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    push_word(rand_word(), 1'b1, 1'b1, 1'b0, NO_RES);
    for (int i = 0; i < SWEEP_WORDS; i++) begin
      push_word(rand_word(), 1'b1, 1'b0, 1'b0, NO_RES);
    end
    wait_idle();
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b1;

    write_start(32'h0000_0000);
    for (int i = 0; i < 40; i++) begin
      push_word(rand_word(), 1'($urandom_range(1)), $urandom_range(99) < 5, 1'b0, NO_RES);
    end
    wait_idle();
    repeat (8) @(posedge clk);

    if (n_err == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/arc_pkg.sv
rtl/arc_ifs.sv
rtl/arc_front.sv
rtl/arc_decode.sv
rtl/arm_pc_relative_ref_classifier.sv
rtl/arc_checker.sv
test/tb_top.sv
